>>> rtl/core/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types, widths and constants of the oriented box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int RotWidth  = 48;
   localparam int CsrData   = 64;
   localparam int CsrAddr   = 6;
   localparam int OffWidth  = 16;
   localparam int HalfWidth = 15;

   typedef logic [RotWidth-1:0]         rot_col_type;
   typedef logic signed [OffWidth-1:0]  offset_type;
   typedef logic [HalfWidth-1:0]        half_type;
   typedef logic signed [15:0]          q14_type;

   typedef enum logic [2:0] {
      REG_ROT_A_COL0 = 3'd0,
      REG_ROT_A_COL1 = 3'd1,
      REG_ROT_A_COL2 = 3'd2,
      REG_ROT_B_COL0 = 3'd3,
      REG_ROT_B_COL1 = 3'd4,
      REG_ROT_B_COL2 = 3'd5
   } reg_index_type;

   localparam rot_col_type RotCol0Reset = 48'h0000_0000_4000;
   localparam rot_col_type RotCol1Reset = 48'h0000_4000_0000;
   localparam rot_col_type RotCol2Reset = 48'h4000_0000_0000;

   localparam logic [1:0] Next1 [3] = '{2'd1, 2'd2, 2'd0};
   localparam logic [1:0] Next2 [3] = '{2'd2, 2'd0, 2'd1};

   function automatic q14_type rot_entry(input rot_col_type col, input logic [1:0] row);
      q14_type e;
      unique case (row)
         2'd0: e = col[15:0];
         2'd1: e = col[31:16];
         default: e = col[47:32];
      endcase
      return e;
   endfunction

endpackage

>>> rtl/core/obb_stream_if.sv
// ----------------------------------------------------------------------------
// obb_req_if / obb_rsp_if
// Valid/ready channels carrying box pair items and overlap results.
// ----------------------------------------------------------------------------
interface obb_req_if;
   import obb_pkg::*;
   logic       valid;
   logic       ready;
   offset_type offset_x;
   offset_type offset_y;
   offset_type offset_z;
   half_type   half_a_x;
   half_type   half_a_y;
   half_type   half_a_z;
   half_type   half_b_x;
   half_type   half_b_y;
   half_type   half_b_z;
   modport source (output valid, offset_x, offset_y, offset_z, half_a_x, half_a_y,
                   half_a_z, half_b_x, half_b_y, half_b_z, input ready);
   modport sink   (input valid, offset_x, offset_y, offset_z, half_a_x, half_a_y,
                   half_a_z, half_b_x, half_b_y, half_b_z, output ready);
endinterface

interface obb_rsp_if;
   logic valid;
   logic ready;
   logic overlap;
   modport source (output valid, overlap, input ready);
   modport sink   (input valid, overlap, output ready);
endinterface

>>> rtl/core/obb_overlap_test.sv
// ----------------------------------------------------------------------------
// obb_overlap_test
// Separating axis overlap test of two oriented boxes over fifteen axes.
// ----------------------------------------------------------------------------
// Each item passes through four register stages: the rotation and offset
// products, their sums and the rounding of C, the radius and cross products,
// and the final compares, whose result sits in the output register. An item
// is accepted every cycle while the stages ahead of it can advance; a
// stalled output holds only the stages that are full, so bubbles still fill.
module obb_overlap_test (
   input  logic                    clock,
   input  logic                    reset,
   obb_req_if.sink                 req_ch,
   obb_rsp_if.source               rsp_ch,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [obb_pkg::CsrAddr-1:0] paddr,
   input  logic [obb_pkg::CsrData-1:0] pwdata,
   output logic [obb_pkg::CsrData-1:0] prdata,
   output logic                    pready
);
   import obb_pkg::*;

   rot_col_type rot_a_ff [3];
   rot_col_type rot_b_ff [3];
   logic [2:0]  csr_idx;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   logic signed [31:0] pt_ff [3][3];
   logic signed [31:0] pu_ff [3][3];
   logic signed [31:0] pc_ff [3][3][3];
   logic signed [31:0] pt_in [3][3];
   logic signed [31:0] pu_in [3][3];
   logic signed [31:0] pc_in [3][3][3];
   half_type a1_ff [3], b1_ff [3], a2_ff [3], b2_ff [3], a3_ff [3], b3_ff [3];
   half_type ah_in [3], bh_in [3];
   offset_type d_in [3];

   logic signed [33:0] t_ff [3], u_ff [3], t_in [3], u_in [3];
   logic signed [19:0] c_ff [3][3], c_in [3][3];

   logic [32:0]        tabs_ff [3], uabs_ff [3], tabs_in [3], uabs_in [3];
   logic [32:0]        ac_ff [3][3][3], bc_ff [3][3][3], ac_in [3][3][3], bc_in [3][3][3];
   logic signed [53:0] tc_ff [3][3][3], tc_in [3][3][3];
   logic [17:0]        cabs [3][3];

   logic overlap_ff, overlap_in;

   assign csr_idx = paddr[5:3];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_a_ff[0] <= RotCol0Reset;
         rot_a_ff[1] <= RotCol1Reset;
         rot_a_ff[2] <= RotCol2Reset;
         rot_b_ff[0] <= RotCol0Reset;
         rot_b_ff[1] <= RotCol1Reset;
         rot_b_ff[2] <= RotCol2Reset;
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_idx)
            REG_ROT_A_COL0: rot_a_ff[0] <= pwdata[RotWidth-1:0];
            REG_ROT_A_COL1: rot_a_ff[1] <= pwdata[RotWidth-1:0];
            REG_ROT_A_COL2: rot_a_ff[2] <= pwdata[RotWidth-1:0];
            REG_ROT_B_COL0: rot_b_ff[0] <= pwdata[RotWidth-1:0];
            REG_ROT_B_COL1: rot_b_ff[1] <= pwdata[RotWidth-1:0];
            REG_ROT_B_COL2: rot_b_ff[2] <= pwdata[RotWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ROT_A_COL0: prdata = {16'd0, rot_a_ff[0]};
         REG_ROT_A_COL1: prdata = {16'd0, rot_a_ff[1]};
         REG_ROT_A_COL2: prdata = {16'd0, rot_a_ff[2]};
         REG_ROT_B_COL0: prdata = {16'd0, rot_b_ff[0]};
         REG_ROT_B_COL1: prdata = {16'd0, rot_b_ff[1]};
         REG_ROT_B_COL2: prdata = {16'd0, rot_b_ff[2]};
         default:        prdata = '0;
      endcase
   end

   assign adv4 = !v4_ff || rsp_ch.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ch.ready = adv1;
   assign rsp_ch.valid = v4_ff;
   assign rsp_ch.overlap = overlap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_ch.valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (adv4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_comb begin
      d_in[0] = req_ch.offset_x;
      d_in[1] = req_ch.offset_y;
      d_in[2] = req_ch.offset_z;
      ah_in[0] = req_ch.half_a_x;
      ah_in[1] = req_ch.half_a_y;
      ah_in[2] = req_ch.half_a_z;
      bh_in[0] = req_ch.half_b_x;
      bh_in[1] = req_ch.half_b_y;
      bh_in[2] = req_ch.half_b_z;
      for (int i = 0; i < 3; i++) begin
         for (int r = 0; r < 3; r++) begin
            pt_in[i][r] = rot_entry(rot_a_ff[i], 2'(r)) * d_in[r];
            pu_in[i][r] = rot_entry(rot_b_ff[i], 2'(r)) * d_in[r];
            for (int j = 0; j < 3; j++) begin
               pc_in[i][j][r] = rot_entry(rot_a_ff[i], 2'(r)) * rot_entry(rot_b_ff[j], 2'(r));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         pt_ff <= pt_in;
         pu_ff <= pu_in;
         pc_ff <= pc_in;
         a1_ff <= ah_in;
         b1_ff <= bh_in;
      end
   end

   always_comb begin
      logic signed [33:0] ps;
      for (int i = 0; i < 3; i++) begin
         t_in[i] = 34'(pt_ff[i][0]) + 34'(pt_ff[i][1]) + 34'(pt_ff[i][2]);
         u_in[i] = 34'(pu_ff[i][0]) + 34'(pu_ff[i][1]) + 34'(pu_ff[i][2]);
         for (int j = 0; j < 3; j++) begin
            ps = 34'(pc_ff[i][j][0]) + 34'(pc_ff[i][j][1]) + 34'(pc_ff[i][j][2])
               + 34'sd8192;
            c_in[i][j] = ps[33:14];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         t_ff  <= t_in;
         u_ff  <= u_in;
         c_ff  <= c_in;
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
      end
   end

   always_comb begin
      logic signed [33:0] ng;
      for (int i = 0; i < 3; i++) begin
         ng = -t_ff[i];
         tabs_in[i] = t_ff[i][33] ? ng[32:0] : t_ff[i][32:0];
         ng = -u_ff[i];
         uabs_in[i] = u_ff[i][33] ? ng[32:0] : u_ff[i][32:0];
         for (int j = 0; j < 3; j++) begin
            cabs[i][j] = c_ff[i][j][19] ? 18'(-c_ff[i][j]) : c_ff[i][j][17:0];
         end
      end
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < 3; j++) begin
               ac_in[k][m][j] = 33'(a2_ff[k]) * 33'(cabs[m][j]);
               bc_in[k][m][j] = 33'(b2_ff[k]) * 33'(cabs[m][j]);
               tc_in[k][m][j] = 54'(t_ff[k]) * 54'(c_ff[m][j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         tabs_ff <= tabs_in;
         uabs_ff <= uabs_in;
         ac_ff   <= ac_in;
         bc_ff   <= bc_in;
         tc_ff   <= tc_in;
         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
      end
   end

   always_comb begin
      logic               sep;
      logic [35:0]        rad;
      logic signed [54:0] diff;
      logic [54:0]        rr;
      logic [34:0]        rsum;
      logic [1:0]         i1, i2, j1, j2;
      sep = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rad = {7'd0, a3_ff[i], 14'd0} + 36'(bc_ff[0][i][0]) + 36'(bc_ff[1][i][1])
             + 36'(bc_ff[2][i][2]);
         if (36'(tabs_ff[i]) > rad) begin
            sep = 1'b1;
         end
         rad = {7'd0, b3_ff[i], 14'd0} + 36'(ac_ff[0][0][i]) + 36'(ac_ff[1][1][i])
             + 36'(ac_ff[2][2][i]);
         if (36'(uabs_ff[i]) > rad) begin
            sep = 1'b1;
         end
      end
      for (int i = 0; i < 3; i++) begin
         i1 = Next1[i];
         i2 = Next2[i];
         for (int j = 0; j < 3; j++) begin
            j1 = Next1[j];
            j2 = Next2[j];
            diff = 55'(tc_ff[i2][i1][j]) - 55'(tc_ff[i1][i2][j]);
            rr   = diff[54] ? 55'(-diff) : 55'(diff);
            rsum = 35'(ac_ff[i1][i2][j]) + 35'(ac_ff[i2][i1][j])
                 + 35'(bc_ff[j1][i][j2]) + 35'(bc_ff[j2][i][j1]);
            if (rr > {6'd0, rsum, 14'd0}) begin
               sep = 1'b1;
            end
         end
      end
      overlap_in = !sep;
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         overlap_ff <= overlap_in;
      end
   end

endmodule
